// ===== hdl/pbsb_pkg.sv =====
// Shared types, widths and helpers for the projected box screen bounds unit.
// No dependencies; every other file imports this package.
package pbsb_pkg;

  localparam int CORNER_COUNT = 8;
  localparam int CNT_W = $clog2(CORNER_COUNT);
  localparam int COORD_W = 32;
  localparam int CFG_W = 64;
  localparam int SCREEN_REG_W = 24;
  localparam int SCR_W = 12;
  localparam int PROD_W = 64;
  localparam int ROW_W = 58;
  localparam int MAG_W = 58;
  localparam int FRAC_W = 16;
  localparam int SAT_SHIFT = 20;
  localparam int QUO_W = FRAC_W + SAT_SHIFT;
  localparam int OFF_W = QUO_W + SCR_W - 1;
  localparam int POS_W = 49;
  localparam int TR_W = POS_W - FRAC_W;
  localparam int SPAN_W = POS_W + 1 - FRAC_W;
  localparam int OUT_W = 16;

  localparam logic signed [ROW_W-1:0] W_MIN = ROW_W'(4294967);
  localparam logic [SCREEN_REG_W-1:0] SCREEN_RESET = SCREEN_REG_W'(4425600);

  typedef enum logic [2:0] {
    REG_X01    = 3'd0,
    REG_X23    = 3'd1,
    REG_Y01    = 3'd2,
    REG_Y23    = 3'd3,
    REG_W01    = 3'd4,
    REG_W23    = 3'd5,
    REG_SCREEN = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic front;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] r;
    logic [QUO_W-1:0] q;
  } div_lane_t;

  typedef struct packed {
    logic                    valid;
    logic                    front;
    logic signed [TR_W-1:0]  left;
    logic signed [TR_W-1:0]  row;
    logic [SPAN_W-1:0]       width;
    logic [SPAN_W-1:0]       height;
  } result_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic div_lane_t div_step(div_lane_t cur, logic [MAG_W-1:0] den);
    logic [MAG_W:0] r2;
    logic           ge;
    div_lane_t      nxt;
    r2 = {cur.r, cur.q[QUO_W-1]};
    ge = (r2 >= {1'b0, den});
    nxt.r = ge ? MAG_W'(r2 - {1'b0, den}) : MAG_W'(r2);
    nxt.q = {cur.q[QUO_W-2:0], ge};
    return nxt;
  endfunction

endpackage

// ===== hdl/pbsb_project.sv =====
// Projection front end: nine products, row sums, then depth test and magnitudes.
// Depends on pbsb_pkg.
module pbsb_project import pbsb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  tag_t                      tag_in,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] pz,
  input  logic [5:0][CFG_W-1:0]     coefs,
  output side_t                     side,
  output logic [MAG_W-1:0]          num_x,
  output logic [MAG_W-1:0]          num_y,
  output logic [MAG_W-1:0]          den
);

  tag_t tag1, tag2;
  logic signed [PROD_W-1:0] prod [9];
  logic signed [ROW_W-1:0]  row_sum [3];
  logic signed [ROW_W-1:0]  row [3];
  logic [MAG_W-1:0]         num_x_c, num_y_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      side <= '0;
    end else if (en) begin
      tag1 <= tag_in;
      tag2 <= tag1;
      side.tag <= tag2;
      side.front <= row[2] > W_MIN;
      side.neg_x <= row[0][ROW_W-1];
      side.neg_y <= row[1][ROW_W-1];
      side.sat_x <= {{SAT_SHIFT{1'b0}}, num_x_c} >= {row[2], {SAT_SHIFT{1'b0}}};
      side.sat_y <= {{SAT_SHIFT{1'b0}}, num_y_c} >= {row[2], {SAT_SHIFT{1'b0}}};
    end
  end

  assign num_x_c = row[0][ROW_W-1] ? MAG_W'(-row[0]) : MAG_W'(row[0]);
  assign num_y_c = row[1][ROW_W-1] ? MAG_W'(-row[1]) : MAG_W'(row[1]);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = ROW_W'(prod[3*r] >>> 8) + ROW_W'(prod[3*r+1] >>> 8)
                 + ROW_W'(prod[3*r+2] >>> 8)
                 + {{(ROW_W-COORD_W-8){coefs[2*r+1][63]}}, coefs[2*r+1][63:32], 8'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[3*r]   <= $signed(coefs[2*r][31:0])    * px;
        prod[3*r+1] <= $signed(coefs[2*r][63:32])   * py;
        prod[3*r+2] <= $signed(coefs[2*r+1][31:0])  * pz;
        row[r]      <= row_sum[r];
      end
      num_x <= num_x_c;
      num_y <= num_y_c;
      den   <= MAG_W'(row[2]);
    end
  end

endmodule

// ===== hdl/pbsb_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, x and y lanes side by side.
// Depends on pbsb_pkg.
module pbsb_divider import pbsb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  side_t            side_in,
  input  logic [MAG_W-1:0] num_x,
  input  logic [MAG_W-1:0] num_y,
  input  logic [MAG_W-1:0] den,
  output side_t            side_out,
  output logic [QUO_W-1:0] ratio_x,
  output logic [QUO_W-1:0] ratio_y
);

  side_t            side_s [QUO_W];
  div_lane_t        lx [QUO_W];
  div_lane_t        ly [QUO_W];
  logic [MAG_W-1:0] den_s [QUO_W];
  div_lane_t        init_x, init_y;

  // Integer part below 2^20 means num >> 20 already sits below den.
  assign init_x = '{r: MAG_W'(num_x >> SAT_SHIFT),
                    q: {num_x[SAT_SHIFT-1:0], {FRAC_W{1'b0}}}};
  assign init_y = '{r: MAG_W'(num_y >> SAT_SHIFT),
                    q: {num_y[SAT_SHIFT-1:0], {FRAC_W{1'b0}}}};

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    side_t            side_p;
    div_lane_t        px, py;
    logic [MAG_W-1:0] dp;
    if (k == 0) begin : g_first
      assign side_p = side_in;
      assign px = init_x;
      assign py = init_y;
      assign dp = den;
    end else begin : g_next
      assign side_p = side_s[k-1];
      assign px = lx[k-1];
      assign py = ly[k-1];
      assign dp = den_s[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        side_s[k] <= '0;
      end else if (en) begin
        side_s[k] <= side_p;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lx[k]    <= div_step(px, dp);
        ly[k]    <= div_step(py, dp);
        den_s[k] <= dp;
      end
    end
  end

  assign side_out = side_s[QUO_W-1];
  assign ratio_x  = side_out.sat_x ? '1 : lx[QUO_W-1].q;
  assign ratio_y  = side_out.sat_y ? '1 : ly[QUO_W-1].q;

endmodule

// ===== hdl/pbsb_reduce.sv =====
// Screen mapping, min/max over the corners of a box, and truncation of the bounds.
// Depends on pbsb_pkg.
module pbsb_reduce import pbsb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  side_t            side_in,
  input  logic [QUO_W-1:0] ratio_x,
  input  logic [QUO_W-1:0] ratio_y,
  input  logic [SCR_W-1:0] scr_w,
  input  logic [SCR_W-1:0] scr_h,
  output result_t          res
);

  side_t side_a, side_b;
  logic [OFF_W-1:0] off_x, off_y;
  logic signed [POS_W-1:0] sx, sy;
  logic signed [POS_W-1:0] min_x, max_x, min_y, max_y;
  logic front_acc, acc_valid;
  logic signed [POS_W-1:0] half_w, half_h, off_xs, off_ys;

  function automatic logic signed [TR_W-1:0] trunc_q16(logic signed [POS_W-1:0] v);
    logic [POS_W-1:0] mag;
    logic [TR_W-1:0]  sh;
    mag = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
    sh  = TR_W'(mag >> FRAC_W);
    return v[POS_W-1] ? -$signed(sh) : $signed(sh);
  endfunction

  assign half_w = {{(POS_W-SCR_W-15){1'b0}}, scr_w, 15'b0};
  assign half_h = {{(POS_W-SCR_W-15){1'b0}}, scr_h, 15'b0};
  assign off_xs = side_a.neg_x ? -$signed(POS_W'(off_x)) : $signed(POS_W'(off_x));
  assign off_ys = side_a.neg_y ? -$signed(POS_W'(off_y)) : $signed(POS_W'(off_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a    <= '0;
      side_b    <= '0;
      acc_valid <= 1'b0;
      res.valid <= 1'b0;
    end else if (en) begin
      side_a    <= side_in;
      side_b    <= side_a;
      acc_valid <= side_b.tag.valid && side_b.tag.last;
      res.valid <= acc_valid;
      off_x <= OFF_W'(({12'b0, ratio_x} * {{QUO_W{1'b0}}, scr_w}) >> 1);
      off_y <= OFF_W'(({12'b0, ratio_y} * {{QUO_W{1'b0}}, scr_h}) >> 1);
      sx <= half_w + off_xs + POS_W'(32768);
      sy <= half_h - off_ys - POS_W'(32768);
      // fold each corner into the running bounds; the first corner restarts them
      if (side_b.tag.valid) begin
        if (side_b.tag.first) begin
          min_x <= sx;
          max_x <= sx;
          min_y <= sy;
          max_y <= sy;
          front_acc <= side_b.front;
        end else begin
          if (sx < min_x) min_x <= sx;
          if (sx > max_x) max_x <= sx;
          if (sy < min_y) min_y <= sy;
          if (sy > max_y) max_y <= sy;
          front_acc <= front_acc && side_b.front;
        end
      end
      res.front  <= front_acc;
      res.left   <= trunc_q16(min_x);
      res.row    <= trunc_q16(min_y);
      res.width  <= SPAN_W'(({max_x[POS_W-1], max_x} - {min_x[POS_W-1], min_x}) >> FRAC_W);
      res.height <= SPAN_W'(({max_y[POS_W-1], max_y} - {min_y[POS_W-1], min_y}) >> FRAC_W);
    end
  end

endmodule

// ===== hdl/projected_box_screen_bounds_unit.sv =====
// Projected box screen bounds: takes one box word, and one corner per cycle enters the
// projection pipeline while the output does not stall, driven by the corner sequencer;
// the next box word can be taken while the last corner enters. A result word passes
// 3 projection stages, 36 divider stages, 4 mapping and reduction stages and the output
// register, and is formed once the last corner of the box reaches the reduction.
// Synchronous reset clears the valid bits and restores the registers to defaults.
module projected_box_screen_bounds_unit import pbsb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] min_x,
  input  logic signed [COORD_W-1:0] min_y,
  input  logic signed [COORD_W-1:0] min_z,
  input  logic signed [COORD_W-1:0] max_x,
  input  logic signed [COORD_W-1:0] max_y,
  input  logic signed [COORD_W-1:0] max_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   box_left,
  output logic signed [OUT_W-1:0]   box_low_row,
  output logic [OUT_W-1:0]          box_width,
  output logic [OUT_W-1:0]          box_height,
  output logic                      on_screen
);

  logic [5:0][CFG_W-1:0]     coefs;
  logic [SCREEN_REG_W-1:0]   screen;
  logic [SCR_W-1:0]          scr_w, scr_h;
  logic                      en, accept, busy;
  logic [CNT_W-1:0]          cnt;
  logic signed [COORD_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic signed [COORD_W-1:0] px, py, pz;
  tag_t                      tag0;
  side_t                     side_p, side_d;
  logic [MAG_W-1:0]          num_x, num_y, den;
  logic [QUO_W-1:0]          ratio_x, ratio_y;
  result_t                   res;
  logic                      last_corner;
  logic signed [TR_W+3:0]    right_end, bottom_end;
  logic                      visible;

  assign scr_w = screen[SCR_W-1:0];
  assign scr_h = screen[2*SCR_W-1:SCR_W];

  // the whole pipeline holds while a finished word waits
  assign en          = !out_valid || out_ready;
  assign last_corner = (cnt == CNT_W'(CORNER_COUNT - 1));
  assign in_ready    = en && (!busy || last_corner);
  assign accept      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs  <= '0;
      screen <= SCREEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X01, REG_X23, REG_Y01, REG_Y23, REG_W01, REG_W23:
          coefs[cfg_index] <= cfg_data;
        REG_SCREEN: screen <= cfg_data[SCREEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (en && busy) begin
      cnt <= cnt + 1'b1;
      if (last_corner) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo_x <= min_x;
      lo_y <= min_y;
      lo_z <= min_z;
      hi_x <= max_x;
      hi_y <= max_y;
      hi_z <= max_z;
    end
  end

  assign px   = cnt[2] ? hi_x : lo_x;
  assign py   = cnt[1] ? hi_y : lo_y;
  assign pz   = cnt[0] ? hi_z : lo_z;
  assign tag0 = '{valid: busy, first: (cnt == '0), last: last_corner};

  pbsb_project u_project (
    .clk(clk), .rst(rst), .en(en), .tag_in(tag0),
    .px(px), .py(py), .pz(pz), .coefs(coefs),
    .side(side_p), .num_x(num_x), .num_y(num_y), .den(den)
  );

  pbsb_divider u_divider (
    .clk(clk), .rst(rst), .en(en), .side_in(side_p),
    .num_x(num_x), .num_y(num_y), .den(den),
    .side_out(side_d), .ratio_x(ratio_x), .ratio_y(ratio_y)
  );

  pbsb_reduce u_reduce (
    .clk(clk), .rst(rst), .en(en), .side_in(side_d),
    .ratio_x(ratio_x), .ratio_y(ratio_y), .scr_w(scr_w), .scr_h(scr_h),
    .res(res)
  );

  assign right_end  = (TR_W+4)'(res.left) + $signed({3'b0, res.width});
  assign bottom_end = (TR_W+4)'(res.row) + $signed({3'b0, res.height});
  assign visible = !(res.left > $signed({{(TR_W-SCR_W){1'b0}}, scr_w})
                  || right_end < 0
                  || res.row > $signed({{(TR_W-SCR_W){1'b0}}, scr_h})
                  || bottom_end < 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && res.valid) begin
      if (!res.front) begin
        box_left    <= '0;
        box_low_row <= '0;
        box_width   <= '0;
        box_height  <= '0;
        on_screen   <= 1'b0;
      end else begin
        box_left <= (res.left > TR_W'(32767)) ? OUT_W'(32767)
                  : (res.left < -TR_W'(32768)) ? OUT_W'(-32768) : OUT_W'(res.left);
        box_low_row <= (res.row > TR_W'(32767)) ? OUT_W'(32767)
                     : (res.row < -TR_W'(32768)) ? OUT_W'(-32768) : OUT_W'(res.row);
        box_width   <= (res.width > SPAN_W'(65535)) ? '1 : OUT_W'(res.width);
        box_height  <= (res.height > SPAN_W'(65535)) ? '1 : OUT_W'(res.height);
        on_screen   <= visible;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && cnt == '0)) else $error("corner sequencer did not restart");
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cnt == '0)) else $error("corner count moved while idle");
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready) else $error("intake open during stall");
`endif

endmodule
